### sv/ppd_pkg.sv
// point_polyline_distance_unit package: state type and fixed widths
// no dependencies
package ppd_pkg;

   localparam int COORD_W    = 16;
   localparam int DIST_W     = 17;
   localparam int CNT_W      = 7;
   localparam int IDX_W      = 6;
   localparam int MUL_W      = 18;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int FRAC_W     = 16;
   localparam int SQ_W       = 34;
   localparam int ROOT_W     = SQ_W + 2;
   localparam int DIV_STEPS  = FRAC_W;
   localparam int ROOT_STEPS = SQ_W / 2 + 1;
   localparam int STEP_W     = 5;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FETCH_A,
      ST_FETCH_B,
      ST_DOT1,
      ST_DOT2,
      ST_DOT3,
      ST_NORM2,
      ST_CLASSIFY,
      ST_DIV,
      ST_PROJ1,
      ST_PROJ2,
      ST_PROJ3,
      ST_SQ1,
      ST_SQ2,
      ST_SQ3,
      ST_ROOT,
      ST_RSP
   } state_type;

endpackage

### sv/point_polyline_distance_unit.sv
// Distance from a query point to a stored polyline. A load beat (func 0) writes one
// vertex and completes at once, busy stays low. A query beat (func 1) walks the segments
// with one shared 18x18 multiplier, a 16 step restoring divider for the projection and an
// 18 step square root, then shows one result beat for a single cycle, which the receiver
// must take. The divider and projection are skipped for a segment whose nearest point is
// an endpoint. Under two vertices the query goes straight to the result beat with
// no_segments set.
// depends on ppd_pkg, ppd_ram
module point_polyline_distance_unit import ppd_pkg::*; #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_func,
   input  logic [IDX_W-1:0]          req_vertex_index,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   output logic                      rsp_valid,
   output logic [DIST_W-1:0]         rsp_distance,
   output logic                      rsp_no_segments,
   input  logic                      csr_wr_en,
   input  logic [CNT_W-1:0]          csr_wr_data
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int NW = $clog2(MAX_VERTICES + 1) + 1;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]         count_ff;
   logic [NW-1:0]            n_ff;
   logic [NW-1:0]            seg_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [COORD_W-1:0] qx_ff, qy_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [MUL_W-1:0]  vx_ff, vy_ff, wx_ff, wy_ff, dx_ff, dy_ff;
   logic signed [PROD_W-1:0] prod_ff, acc_ff;
   logic signed [SUM_W-1:0]  c1_ff, c2_ff;
   logic [SUM_W:0]           rem_ff;
   logic [FRAC_W-1:0]        t_ff;
   logic [SUM_W-1:0]         best_ff;
   logic                     first_ff;
   logic [ROOT_W-1:0]        rn_ff, res_ff, bit_ff;
   logic                     no_seg_ff;

   logic                     accept;
   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]         new_best;
   logic [SUM_W:0]           rem_sh;
   logic signed [19:0]       proj;
   logic [NW-1:0]            n_sat;
   logic                     more;
   logic [ROOT_W-1:0]        root_try;
   logic                     ram_wr, ram_rd;
   logic [AW-1:0]            ram_rd_addr;
   logic [2*COORD_W-1:0]     ram_rd_data;

   assign accept = start && !busy;
   assign sum    = SUM_W'(acc_ff) + SUM_W'(prod_ff);
   assign rem_sh = {rem_ff[SUM_W-1:0], 1'b0};
   assign proj   = 20'((prod_ff + (prod_ff[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0)))
                       >>> FRAC_W);
   assign more   = (seg_ff + NW'(2)) < n_ff;
   assign root_try = res_ff + bit_ff;
   assign new_best = (first_ff || (unsigned'(sum) < best_ff)) ? unsigned'(sum) : best_ff;
   assign n_sat  = (32'(count_ff) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_ff);

   assign ram_wr = accept && (req_func == FUNC_LOAD) &&
                   (32'(req_vertex_index) < MAX_VERTICES);

   ppd_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_VERTICES)) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (AW'(req_vertex_index)),
      .wr_data ({req_coord_x, req_coord_y}),
      .rd_en   (ram_rd),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_QUERY)) begin
               state_in = (n_sat < NW'(2)) ? ST_RSP : ST_FETCH_A;
            end
         end
         ST_FETCH_A:  state_in = ST_FETCH_B;
         ST_FETCH_B:  state_in = ST_DOT1;
         ST_DOT1:     state_in = ST_DOT2;
         ST_DOT2:     state_in = ST_DOT3;
         ST_DOT3:     state_in = ST_NORM2;
         ST_NORM2:    state_in = ST_CLASSIFY;
         ST_CLASSIFY: begin
            if (c1_ff <= 0 || c1_ff >= sum) begin
               state_in = ST_SQ1;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_PROJ1;
            end
         end
         ST_PROJ1:    state_in = ST_PROJ2;
         ST_PROJ2:    state_in = ST_PROJ3;
         ST_PROJ3:    state_in = ST_SQ1;
         ST_SQ1:      state_in = ST_SQ2;
         ST_SQ2:      state_in = ST_SQ3;
         ST_SQ3:      state_in = more ? ST_FETCH_B : ST_ROOT;
         ST_ROOT: begin
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ST_RSP;
            end
         end
         ST_RSP:      state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and unit controls
   always_comb begin
      busy        = (state_ff != ST_IDLE);
      rsp_valid   = (state_ff == ST_RSP);
      ram_rd      = 1'b0;
      ram_rd_addr = '0;
      op_a        = dx_ff;
      op_b        = dx_ff;
      case (state_ff)
         ST_IDLE: begin
            ram_rd = accept;
         end
         ST_FETCH_A: begin
            ram_rd      = 1'b1;
            ram_rd_addr = AW'(1);
         end
         ST_SQ3: begin
            ram_rd      = more;
            ram_rd_addr = AW'(seg_ff + NW'(2));
         end
         ST_DOT1:  begin op_a = vx_ff;               op_b = wx_ff; end
         ST_DOT2:  begin op_a = vy_ff;               op_b = wy_ff; end
         ST_DOT3:  begin op_a = vx_ff;               op_b = vx_ff; end
         ST_NORM2: begin op_a = vy_ff;               op_b = vy_ff; end
         ST_PROJ1: begin op_a = MUL_W'({2'b00, t_ff}); op_b = vx_ff; end
         ST_PROJ2: begin op_a = MUL_W'({2'b00, t_ff}); op_b = vy_ff; end
         ST_SQ2:   begin op_a = dy_ff;               op_b = dy_ff; end
         default: begin
         end
      endcase
   end

   assign rsp_distance    = res_ff[DIST_W-1:0];
   assign rsp_no_segments = no_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_QUERY)) begin
               qx_ff    <= req_coord_x;
               qy_ff    <= req_coord_y;
               n_ff     <= n_sat;
               seg_ff   <= '0;
               first_ff <= 1'b1;
               no_seg_ff <= (n_sat < NW'(2));
               res_ff   <= '0;
               best_ff  <= '0;
            end
         end
         ST_FETCH_A: begin
            ax_ff <= ram_rd_data[2*COORD_W-1:COORD_W];
            ay_ff <= ram_rd_data[COORD_W-1:0];
         end
         ST_FETCH_B: begin
            bx_ff <= ram_rd_data[2*COORD_W-1:COORD_W];
            by_ff <= ram_rd_data[COORD_W-1:0];
            vx_ff <= MUL_W'(signed'(ram_rd_data[2*COORD_W-1:COORD_W])) - MUL_W'(ax_ff);
            vy_ff <= MUL_W'(signed'(ram_rd_data[COORD_W-1:0])) - MUL_W'(ay_ff);
            wx_ff <= MUL_W'(qx_ff) - MUL_W'(ax_ff);
            wy_ff <= MUL_W'(qy_ff) - MUL_W'(ay_ff);
         end
         ST_DOT2:  acc_ff <= prod_ff;
         ST_DOT3:  c1_ff  <= sum;
         ST_NORM2: acc_ff <= prod_ff;
         ST_CLASSIFY: begin
            c2_ff   <= sum;
            rem_ff  <= (SUM_W + 1)'(unsigned'(c1_ff));
            step_ff <= '0;
            if (c1_ff <= 0) begin
               dx_ff <= wx_ff;
               dy_ff <= wy_ff;
            end else begin
               dx_ff <= MUL_W'(qx_ff) - MUL_W'(bx_ff);
               dy_ff <= MUL_W'(qy_ff) - MUL_W'(by_ff);
            end
         end
         ST_DIV: begin
            step_ff <= step_ff + STEP_W'(1);
            if (rem_sh >= (SUM_W + 1)'(unsigned'(c2_ff))) begin
               rem_ff <= rem_sh - (SUM_W + 1)'(unsigned'(c2_ff));
               t_ff   <= {t_ff[FRAC_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               t_ff   <= {t_ff[FRAC_W-2:0], 1'b0};
            end
         end
         ST_PROJ2: dx_ff <= MUL_W'(20'(qx_ff) - (20'(ax_ff) + proj));
         ST_PROJ3: dy_ff <= MUL_W'(20'(qy_ff) - (20'(ay_ff) + proj));
         ST_SQ2:   acc_ff <= prod_ff;
         ST_SQ3: begin
            best_ff  <= new_best;
            first_ff <= 1'b0;
            rn_ff    <= ROOT_W'(new_best[SQ_W-1:0]);
            res_ff   <= '0;
            bit_ff   <= ROOT_W'(1) << SQ_W;
            step_ff  <= '0;
            seg_ff   <= seg_ff + NW'(1);
            ax_ff    <= bx_ff;
            ay_ff    <= by_ff;
         end
         ST_ROOT: begin
            step_ff <= step_ff + STEP_W'(1);
            bit_ff  <= bit_ff >> 2;
            if (rn_ff >= root_try) begin
               rn_ff  <= rn_ff - root_try;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### sv/ppd_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module ppd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ppd_checker.sv
// port level checks for point_polyline_distance_unit, attached by bind
// depends on ppd_pkg
module ppd_checker import ppd_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                req_func,
   input logic                rsp_valid,
   input logic [DIST_W-1:0]   rsp_distance,
   input logic                rsp_no_segments
);

   // a result beat lasts one cycle
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat longer than one cycle");

   a_beat_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_segments) |-> (rsp_distance == '0))
      else $error("no_segments with nonzero distance");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_QUERY) |=> busy)
      else $error("query did not raise busy");

   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_LOAD) |=> (!busy && !rsp_valid))
      else $error("load caused activity");

endmodule

bind point_polyline_distance_unit ppd_checker u_ppd_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_func        (req_func),
   .rsp_valid       (rsp_valid),
   .rsp_distance    (rsp_distance),
   .rsp_no_segments (rsp_no_segments)
);

### dv/tb.sv
// testbench for point_polyline_distance_unit: loads and queries a polyline, predicts
// each distance in the bench itself and checks every response beat against it
// depends on ppd_pkg and point_polyline_distance_unit
`timescale 1ns / 100ps

module tb;
   import ppd_pkg::*;

   localparam int NUM_SLOTS = 64;

   typedef struct {
      logic                      func;
      logic [IDX_W-1:0]          idx;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } cmd_beat_type;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic              noseg;
   } dist_beat_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_func = FUNC_LOAD;
   logic [IDX_W-1:0]          req_vertex_index = '0;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic                      rsp_valid;
   logic [DIST_W-1:0]         rsp_distance;
   logic                      rsp_no_segments;
   logic                      csr_wr_en = 1'b0;
   logic [CNT_W-1:0]          csr_wr_data = '0;

   cmd_beat_type  pending_cmds[$];
   dist_beat_type expected_dist[$];

   longint poly_x[NUM_SLOTS];
   longint poly_y[NUM_SLOTS];
   bit     slot_loaded[NUM_SLOTS];
   int     poly_count;
   bit     steady_flow;
   int     mismatches;
   int     loads_sent;
   int     queries_sent;
   int     dist_checked;

   always #10 clock = ~clock;

   point_polyline_distance_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_vertex_index(req_vertex_index),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .rsp_valid(rsp_valid), .rsp_distance(rsp_distance),
      .rsp_no_segments(rsp_no_segments),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   function automatic longint trunc_scale(longint t, longint comp);
      return (t * comp) / 65536;
   endfunction

   function automatic longint segment_dist_sq(longint qx, longint qy, longint ax,
                                              longint ay, longint bx, longint by);
      longint vx, vy, wx, wy, c1, c2, t, px, py;
      vx = bx - ax;
      vy = by - ay;
      wx = qx - ax;
      wy = qy - ay;
      c1 = vx * wx + vy * wy;
      if (c1 <= 0) return wx * wx + wy * wy;
      c2 = vx * vx + vy * vy;
      if (c1 >= c2) return (qx - bx) * (qx - bx) + (qy - by) * (qy - by);
      t = (c1 <<< 16) / c2;
      px = qx - (ax + trunc_scale(t, vx));
      py = qy - (ay + trunc_scale(t, vy));
      return px * px + py * py;
   endfunction

   function automatic longint root_floor(longint n);
      longint res, bitv;
      res = 0;
      bitv = longint'(1) <<< 34;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   function automatic void predict_distance(cmd_beat_type c);
      dist_beat_type e;
      longint best, d;
      int n;
      if (c.func == FUNC_LOAD) begin
         poly_x[c.idx] = c.x;
         poly_y[c.idx] = c.y;
         return;
      end
      n = (poly_count > NUM_SLOTS) ? NUM_SLOTS : poly_count;
      if (n < 2) begin
         e.distance = '0;
         e.noseg = 1'b1;
      end else begin
         best = segment_dist_sq(c.x, c.y, poly_x[0], poly_y[0], poly_x[1], poly_y[1]);
         for (int i = 1; i + 1 < n; i++) begin
            d = segment_dist_sq(c.x, c.y, poly_x[i], poly_y[i], poly_x[i+1], poly_y[i+1]);
            if (d < best) best = d;
         end
         best = best & ((longint'(1) <<< SQ_W) - 1);
         e.distance = DIST_W'(root_floor(best));
         e.noseg = 1'b0;
      end
      expected_dist.push_back(e);
   endfunction

   // driver
   always @(posedge clock) begin
      cmd_beat_type c;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            c.func = req_func;
            c.idx = req_vertex_index;
            c.x = req_coord_x;
            c.y = req_coord_y;
            predict_distance(c);
         end
         if (pending_cmds.size() > 0 && (steady_flow || $urandom_range(0, 99) >= 22)) begin
            c = pending_cmds.pop_front();
            start <= 1'b1;
            req_func <= c.func;
            req_vertex_index <= c.idx;
            req_coord_x <= c.x;
            req_coord_y <= c.y;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      dist_beat_type e;
      if (!reset && rsp_valid) begin
         if (expected_dist.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: distance %0d no_segments %0b",
                        rsp_distance, rsp_no_segments);
         end else begin
            e = expected_dist.pop_front();
            dist_checked++;
            if (rsp_distance !== e.distance || rsp_no_segments !== e.noseg) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: distance exp %0d got %0d, no_segments exp %0b got %0b",
                           e.distance, rsp_distance, e.noseg, rsp_no_segments);
            end
         end
      end
   end

   function automatic logic signed [COORD_W-1:0] pick_coord();
      if ($urandom_range(0, 1)) return COORD_W'($urandom);
      return COORD_W'(int'($urandom_range(0, 2047)) - 1024);
   endfunction

   function automatic void push_load(int idx, int x, int y);
      cmd_beat_type c;
      c.func = FUNC_LOAD;
      c.idx = IDX_W'(idx);
      c.x = COORD_W'(x);
      c.y = COORD_W'(y);
      slot_loaded[idx] = 1'b1;
      pending_cmds.push_back(c);
      loads_sent++;
   endfunction

   // queries only go out when every vertex in use has been loaded, or when under two are in use
   function automatic void push_query(int x, int y);
      cmd_beat_type c;
      int n;
      n = (poly_count > NUM_SLOTS) ? NUM_SLOTS : poly_count;
      if (n >= 2)
         for (int i = 0; i < n; i++)
            if (!slot_loaded[i]) return;
      c.func = FUNC_QUERY;
      c.idx = IDX_W'($urandom);
      c.x = COORD_W'(x);
      c.y = COORD_W'(y);
      pending_cmds.push_back(c);
      queries_sent++;
   endfunction

   task automatic drain();
      while (pending_cmds.size() > 0 || start || expected_dist.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_count(int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CNT_W'(value);
      poly_count = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(int count, int beats);
      set_count(count);
      for (int k = 0; k < beats; k++) begin
         if ($urandom_range(0, 99) < 30)
            push_load($urandom_range(0, NUM_SLOTS - 1), int'(pick_coord()),
                      int'(pick_coord()));
         else
            push_query(int'(pick_coord()), int'(pick_coord()));
      end
      drain();
   endtask

   initial begin
      int counts[10];
      poly_count = 0;
      steady_flow = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty and single-vertex polylines, extremes, degenerate segment
      push_query(0, 0);
      drain();
      set_count(1);
      push_query(32767, -32768);
      drain();
      push_load(0, -32768, -32768);
      push_load(1, 32767, 32767);
      push_load(2, 32767, 32767);
      push_load(3, 32767, -32768);
      push_load(4, 256, 0);
      drain();
      set_count(5);
      push_query(-32768, -32768);
      push_query(32767, -32768);
      push_query(-32768, 32767);
      push_query(0, 0);
      push_query(-32768, 0);
      push_query(32767, 0);
      push_query(100, 3);
      push_query(-1, -1);
      drain();
      set_count(2);
      push_query(1000, -1000);
      push_query(32767, 32767);
      drain();

      // fill every slot, no gaps on the sender side here
      set_count(0);
      steady_flow = 1'b1;
      for (int i = 0; i < NUM_SLOTS; i++) push_load(i, int'(pick_coord()), int'(pick_coord()));
      push_query(int'(pick_coord()), int'(pick_coord()));
      drain();
      steady_flow = 1'b0;

      counts = '{2, 3, 4, 6, 8, 12, 3, 5, 2, 7};
      foreach (counts[i]) random_phase(counts[i], 30);
      random_phase(NUM_SLOTS, 10);
      random_phase(127, 10);
      random_phase(65, 5);
      random_phase(1, 8);
      random_phase($urandom_range(2, 16), 30);

      $display("covered %0d vertex loads and %0d queries, %0d results checked",
               loads_sent, queries_sent, dist_checked);
      $display("vertex counts from 0 to 127 including saturation, %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("timeout with %0d results outstanding", expected_dist.size());
      $display("Verification failed");
      $finish;
   end

endmodule

### filelist.f
sv/ppd_pkg.sv
sv/ppd_ram.sv
sv/point_polyline_distance_unit.sv
sv/ppd_checker.sv
dv/tb.sv
